// File: rtl/core/radix_digit_converter_top_assert.svh
// Assertion macros for the radix digit converter, clocked on clk_i with reset rst_ni.
// Included by radix_digit_converter_top; needs no other file.
`ifndef RADIX_DIGIT_CONVERTER_TOP_ASSERT_SVH
`define RADIX_DIGIT_CONVERTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RDC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RDC_ASSERT_SAME(lbl, ante, cons)
`define RDC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/core/rdc_pkg.sv
// Package of the radix digit converter: payload types, control structs and constants.
// No dependencies.
package rdc_pkg;

  localparam logic [5:0] RADIX_MIN  = 6'd2;
  localparam logic [5:0] RADIX_MAX  = 6'd36;
  localparam logic [5:0] DEC_DIGITS = 6'd10;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_A    = 8'h41;

  typedef struct packed {
    logic [31:0] value;
    logic [5:0]  radix;
  } rdc_in_t;

  typedef struct packed {
    logic [7:0] digit_char;
    logic       last_digit;
  } rdc_out_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic store;
    logic rd;
    logic emit;
  } rdc_cmd_t;

  typedef struct packed {
    logic quo_zero;
    logic idx_zero;
  } rdc_sts_t;

  function automatic logic [7:0] digit_to_ascii(input logic [5:0] d);
    logic [7:0] c;
    if (d < DEC_DIGITS) begin
      c = ASCII_ZERO + {2'b00, d};
    end else begin
      c = ASCII_A + {2'b00, d} - {2'b00, DEC_DIGITS};
    end
    return c;
  endfunction

endpackage

// File: rtl/core/radix_digit_converter_top.sv
// Top level of the radix digit converter: joins controller and datapath.
// Depends on rdc_pkg, rdc_ctrl, rdc_datapath and radix_digit_converter_top_assert.svh.
//
//  Channel   Ports                              Transfer
//  input     start, busy, data_i                start high while busy is low
//  result    result_valid_o, result_o           result_valid_o high for one cycle
//
// Each digit comes from the one-bit-per-cycle divider run over all VALUE_BITS quotient bits,
// followed by a digit store; output then needs a memory read and a result register write
// per digit.
// Reset clears the controller, the digit count and the result strobe.
// The receiver cannot stall; busy falls in the cycle the final digit is registered.
`include "radix_digit_converter_top_assert.svh"
module radix_digit_converter_top #(
  parameter int VALUE_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  rdc_pkg::rdc_in_t  data_i,
  output rdc_pkg::rdc_out_t result_o,
  output logic              result_valid_o
);

  rdc_pkg::rdc_cmd_t cmd;
  rdc_pkg::rdc_sts_t sts;

  rdc_ctrl #(
    .VALUE_BITS(VALUE_BITS)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  rdc_datapath #(
    .VALUE_BITS(VALUE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_i        (data_i),
    .sts_o         (sts),
    .result_o      (result_o),
    .result_valid_o(result_valid_o)
  );

  `RDC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `RDC_ASSERT_SAME(a_cmd_onehot, 1'b1, $onehot0(cmd))
  `RDC_ASSERT_NEXT(a_emit_strobe, cmd.emit, result_valid_o)
  `RDC_ASSERT_NEXT(a_last_ends, result_valid_o && result_o.last_digit, !result_valid_o)

endmodule

// File: rtl/core/rdc_ctrl.sv
// Controller of the radix digit converter: sequences division steps, digit stores and output.
// Depends on rdc_pkg.
module rdc_ctrl #(
  parameter int VALUE_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  rdc_pkg::rdc_sts_t sts_i,
  output rdc_pkg::rdc_cmd_t cmd_o,
  output logic              busy_o
);

  localparam int CW = $clog2(VALUE_BITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_STORE,
    S_READ,
    S_EMIT
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] bit_q, bit_d;

  always_comb begin
    state_d = state_q;
    bit_d   = bit_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          bit_d      = CW'(VALUE_BITS - 1);
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (bit_q == '0) begin
          state_d = S_STORE;
        end else begin
          bit_d = bit_q - 1'b1;
        end
      end
      S_STORE: begin
        cmd_o.store = 1'b1;
        if (sts_i.quo_zero) begin
          state_d = S_READ;
        end else begin
          bit_d   = CW'(VALUE_BITS - 1);
          state_d = S_DIV;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d    = sts_i.idx_zero ? S_IDLE : S_READ;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// File: rtl/core/rdc_datapath.sv
// Datapath of the radix digit converter: bit-serial divider, digit memory and result register.
// Depends on rdc_pkg.
module rdc_datapath #(
  parameter int VALUE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rdc_pkg::rdc_cmd_t  cmd_i,
  input  rdc_pkg::rdc_in_t   data_i,
  output rdc_pkg::rdc_sts_t  sts_o,
  output rdc_pkg::rdc_out_t  result_o,
  output logic               result_valid_o
);

  localparam int AW = $clog2(VALUE_BITS);
  localparam int NW = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0]    quo_q, quo_d;
  logic [5:0]               rem_q, rem_d;
  logic [5:0]               base_q, base_d;
  logic [NW-1:0]            cnt_q, cnt_d;
  logic [5:0]               rd_data_q;
  logic [5:0]               mem_q [VALUE_BITS];
  rdc_pkg::rdc_out_t        result_q;
  logic                     valid_q;
  logic [VALUE_BITS+31:0]   value_wide;
  logic [6:0]               rem_shift;
  logic                     q_bit;
  logic [NW-1:0]            cnt_dec;

  assign value_wide = {{VALUE_BITS{1'b0}}, data_i.value};
  assign rem_shift  = {rem_q, quo_q[VALUE_BITS-1]};
  assign q_bit      = (rem_shift >= {1'b0, base_q});
  assign cnt_dec    = cnt_q - 1'b1;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    base_d = base_q;
    cnt_d  = cnt_q;
    if (cmd_i.load) begin
      quo_d = value_wide[VALUE_BITS-1:0];
      rem_d = '0;
      cnt_d = '0;
      if (data_i.radix < rdc_pkg::RADIX_MIN) begin
        base_d = rdc_pkg::RADIX_MIN;
      end else if (data_i.radix > rdc_pkg::RADIX_MAX) begin
        base_d = rdc_pkg::RADIX_MAX;
      end else begin
        base_d = data_i.radix;
      end
    end else if (cmd_i.div_step) begin
      quo_d = {quo_q[VALUE_BITS-2:0], q_bit};
      rem_d = q_bit ? 6'(rem_shift - {1'b0, base_q}) : rem_shift[5:0];
    end else if (cmd_i.store) begin
      rem_d = '0;
      cnt_d = cnt_q + 1'b1;
    end else if (cmd_i.rd) begin
      cnt_d = cnt_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    base_q <= base_d;
    if (cmd_i.store) begin
      mem_q[cnt_q[AW-1:0]] <= rem_q;
    end
    if (cmd_i.rd) begin
      rd_data_q <= mem_q[cnt_dec[AW-1:0]];
    end
    if (cmd_i.emit) begin
      result_q.digit_char <= rdc_pkg::digit_to_ascii(rd_data_q);
      result_q.last_digit <= (cnt_q == '0);
    end
  end

  assign sts_o.quo_zero  = (quo_q == '0);
  assign sts_o.idx_zero  = (cnt_q == '0);
  assign result_o        = result_q;
  assign result_valid_o  = valid_q;

endmodule

// File: test/testbench.sv
// Self-checking testbench for radix_digit_converter_top: drives conversion requests and checks
// every emitted digit character against a built-in predictor of the repeated division.
// Depends on rdc_pkg and the RTL of radix_digit_converter_top.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 1200;

  typedef struct {
    rdc_pkg::rdc_in_t payload;
    int unsigned      gap;
  } conversion_req_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  rdc_pkg::rdc_in_t  data_i = '0;
  rdc_pkg::rdc_out_t result_o;
  logic              result_valid_o;

  conversion_req_t   requests_pending[$];
  rdc_pkg::rdc_out_t digits_expected[$];
  int                error_count = 0;
  int                cycle_count = 0;

  radix_digit_converter_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .data_i        (data_i),
    .result_o      (result_o),
    .result_valid_o(result_valid_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic void predict_digits(rdc_pkg::rdc_in_t req);
    int unsigned       n;
    int unsigned       base;
    int unsigned       count;
    logic [5:0]        rem[32];
    rdc_pkg::rdc_out_t digit;
    n = req.value;
    base = req.radix;
    if (base < rdc_pkg::RADIX_MIN) base = rdc_pkg::RADIX_MIN;
    if (base > rdc_pkg::RADIX_MAX) base = rdc_pkg::RADIX_MAX;
    count = 0;
    do begin
      rem[count] = 6'(n % base);
      n = n / base;
      count++;
    end while (n != 0);
    for (int k = int'(count) - 1; k >= 0; k--) begin
      if (rem[k] < rdc_pkg::DEC_DIGITS) begin
        digit.digit_char = rdc_pkg::ASCII_ZERO + {2'b00, rem[k]};
      end else begin
        digit.digit_char = rdc_pkg::ASCII_A + {2'b00, rem[k]} - {2'b00, rdc_pkg::DEC_DIGITS};
      end
      digit.last_digit = (k == 0);
      digits_expected.push_back(digit);
    end
  endfunction

  function automatic void add_request(logic [31:0] value, logic [5:0] radix,
                                      int unsigned idle_pct);
    conversion_req_t req;
    req.payload.value = value;
    req.payload.radix = radix;
    req.gap = 0;
    if ($urandom_range(99) < idle_pct) begin
      if ($urandom_range(19) == 0) begin
        req.gap = $urandom_range(300, 1);
      end else begin
        req.gap = $urandom_range(8, 1);
      end
    end
    requests_pending.push_back(req);
  endfunction

  always @(posedge clk_i) begin : driver
    conversion_req_t req;
    if (rst_ni) begin
      if (start && !busy) begin
        predict_digits(data_i);
        if (requests_pending.size() > 0 && requests_pending[0].gap == 0) begin
          req = requests_pending.pop_front();
          data_i <= req.payload;
        end else begin
          start <= 1'b0;
        end
      end else if (!start && requests_pending.size() > 0) begin
        if (requests_pending[0].gap > 0) begin
          requests_pending[0].gap = requests_pending[0].gap - 1;
        end else begin
          req = requests_pending.pop_front();
          data_i <= req.payload;
          start <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    rdc_pkg::rdc_out_t want;
    if (rst_ni && result_valid_o) begin
      if (digits_expected.size() == 0) begin
        $error("unexpected transfer: digit_char %0h, last_digit %0b",
               result_o.digit_char, result_o.last_digit);
        error_count++;
      end else begin
        want = digits_expected.pop_front();
        if (result_o.digit_char !== want.digit_char) begin
          $error("digit_char: expected %0h, got %0h", want.digit_char, result_o.digit_char);
          error_count++;
        end
        if (result_o.last_digit !== want.last_digit) begin
          $error("last_digit: expected %0b, got %0b", want.last_digit, result_o.last_digit);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    int unsigned phase_idle[4];
    logic [31:0] value;
    logic [5:0]  radix;
    int unsigned pick;

    phase_idle = '{0, 62, 0, 37};

    add_request(32'd0, 6'd10, 0);
    add_request(32'hFFFF_FFFF, 6'd2, 0);
    add_request(32'hFFFF_FFFF, 6'd36, 0);
    add_request(32'h8000_0000, 6'd2, 0);
    add_request(32'd1, 6'd2, 0);
    add_request(32'd0, 6'd63, 0);
    add_request(32'd5, 6'd0, 0);
    add_request(32'd7, 6'd1, 0);
    add_request(32'd1295, 6'd37, 0);
    add_request(32'hFFFF_FFFF, 6'd63, 0);
    add_request(32'd35, 6'd36, 0);
    add_request(32'd36, 6'd36, 0);
    add_request(32'd10, 6'd16, 0);
    add_request(32'd9, 6'd10, 0);
    add_request(32'd255, 6'd16, 0);
    add_request(32'hDEAD_BEEF, 6'd16, 0);
    add_request(32'd12345, 6'd10, 0);
    add_request(32'h5555_5555, 6'd32, 0);
    add_request(32'hAAAA_AAAA, 6'd3, 0);

    for (int i = 0; i < 312; i++) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        value = $urandom;
      end else if (pick < 55) begin
        value = $urandom_range(1000);
      end else if (pick < 80) begin
        value = $urandom >> $urandom_range(31);
      end else if (pick < 90) begin
        value = 32'hFFFF_FFFF >> $urandom_range(31);
      end else begin
        value = ($urandom_range(1) == 0) ? 32'd0 : 32'hFFFF_FFFF;
      end
      if ($urandom_range(99) < 85) begin
        radix = 6'($urandom_range(36, 2));
      end else begin
        radix = 6'($urandom_range(63));
      end
      add_request(value, radix, phase_idle[i / 78]);
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (requests_pending.size() > 0 || start || digits_expected.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0 && digits_expected.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/rdc_pkg.sv
rtl/core/rdc_ctrl.sv
rtl/core/rdc_datapath.sv
rtl/core/radix_digit_converter_top.sv
test/testbench.sv
